### design/itrt_pkg.sv
package itrt_pkg;

   localparam logic [6:0] MINUS_CODE   = 7'h2D;
   localparam logic [6:0] ZERO_CODE    = 7'h30;
   localparam logic [6:0] LETTER_CODE  = 7'h41;
   localparam logic [5:0] DECIMAL_BASE = 6'd10;
   localparam logic [5:0] MIN_RADIX    = 6'd2;
   localparam logic [5:0] MAX_RADIX    = 6'd36;

   // per-item info that travels beside the magnitude
   typedef struct packed {
      logic [5:0] radix;
      logic       minus;
      logic       bad;
   } job_info_type;

   localparam int INFO_BITS = $bits(job_info_type);

   typedef enum logic [2:0] {
      B_IDLE,
      B_ERR,
      B_DIV,
      B_SIGN,
      B_READ,
      B_EMIT
   } back_state_type;

   // digit value to uppercase ascii glyph
   function automatic logic [6:0] digit_glyph(input logic [5:0] digit);
      logic [6:0] code;
      if (digit < 6'd10) begin
         code = ZERO_CODE + {1'b0, digit};
      end else begin
         code = LETTER_CODE + {1'b0, digit} - 7'd10;
      end
      return code;
   endfunction

endpackage

### design/integer_to_radix_text_top.sv
// each of the D digits comes from the bit-serial divider; after the divider, a sign step
// sends a leading '-' (decimal only), then each character is read from the digit memory
// and then emitted; an output stall holds the sign step and each character
// the back end finishes one item before it takes the next; a bad radix gives one error char;
// a two-entry queue takes new items while the back end works
// reset is synchronous, active high, clears control state; digit memory is not cleared
module integer_to_radix_text_top
   import itrt_pkg::*;
#(
   parameter int WORD_BITS = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [WORD_BITS-1:0] req_value,
   input  logic [5:0]                  req_radix,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [6:0]                  rsp_char_code,
   output logic                        rsp_last,
   output logic                        rsp_bad_radix
);

   localparam int JOB_BITS = WORD_BITS + INFO_BITS;

   logic                 queue_full;
   logic                 queue_empty;
   logic                 queue_pop;
   logic                 push_valid;
   logic [WORD_BITS-1:0] push_mag;
   job_info_type         push_info;
   logic [JOB_BITS-1:0]  pop_data;
   job_info_type         pop_info;

   // accept and classify
   itrt_front #(
      .WORD_BITS (WORD_BITS)
   ) u_front (
      .req_valid  (req_valid),
      .req_value  (req_value),
      .req_radix  (req_radix),
      .queue_full (queue_full),
      .req_stall  (req_stall),
      .push_valid (push_valid),
      .push_mag   (push_mag),
      .push_info  (push_info)
   );

   // decoupling queue
   itrt_queue #(
      .DATA_BITS (JOB_BITS)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_data ({push_mag, push_info}),
      .pop       (queue_pop),
      .pop_data  (pop_data),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   assign pop_info = job_info_type'(pop_data[INFO_BITS-1:0]);

   // divide and emit
   itrt_back #(
      .WORD_BITS (WORD_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .queue_empty   (queue_empty),
      .job_mag       (pop_data[JOB_BITS-1:INFO_BITS]),
      .job_info      (pop_info),
      .queue_pop     (queue_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_char_code (rsp_char_code),
      .rsp_last      (rsp_last),
      .rsp_bad_radix (rsp_bad_radix)
   );

endmodule

### design/itrt_ram.sv
module itrt_ram #(
   parameter int WIDTH = 6,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/itrt_front.sv
module itrt_front
   import itrt_pkg::*;
#(
   parameter int WORD_BITS = 32
) (
   input  logic                        req_valid,
   input  logic signed [WORD_BITS-1:0] req_value,
   input  logic [5:0]                  req_radix,
   input  logic                        queue_full,
   output logic                        req_stall,
   output logic                        push_valid,
   output logic [WORD_BITS-1:0]        push_mag,
   output job_info_type                push_info
);

   logic negative;
   logic bad;

   // classify radix and sign
   assign negative = req_value[WORD_BITS-1];
   assign bad      = (req_radix < MIN_RADIX) || (req_radix > MAX_RADIX);

   // magnitude kept unsigned so the most negative value is exact
   assign push_mag = negative ? (~req_value + WORD_BITS'(1)) : req_value;

   assign push_info.radix = req_radix;
   assign push_info.minus = negative && (req_radix == DECIMAL_BASE) && !bad;
   assign push_info.bad   = bad;

   assign push_valid = req_valid && !queue_full;
   assign req_stall  = queue_full;

endmodule

### design/itrt_queue.sv
module itrt_queue #(
   parameter int DATA_BITS = 40
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  logic [DATA_BITS-1:0] push_data,
   input  logic                 pop,
   output logic [DATA_BITS-1:0] pop_data,
   output logic                 full,
   output logic                 empty
);

   logic [DATA_BITS-1:0] slot_ff [2];
   logic                 wr_ptr_ff, wr_ptr_in;
   logic                 rd_ptr_ff, rd_ptr_in;
   logic [1:0]           fill_ff, fill_in;

   assign full     = (fill_ff == 2'd2);
   assign empty    = (fill_ff == 2'd0);
   assign pop_data = slot_ff[rd_ptr_ff];

   // pointer and fill update
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### design/itrt_back.sv
module itrt_back
   import itrt_pkg::*;
#(
   parameter int WORD_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 queue_empty,
   input  logic [WORD_BITS-1:0] job_mag,
   input  job_info_type         job_info,
   output logic                 queue_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [6:0]           rsp_char_code,
   output logic                 rsp_last,
   output logic                 rsp_bad_radix
);

   localparam int IDX_BITS = $clog2(WORD_BITS);
   localparam int CNT_BITS = $clog2(WORD_BITS + 1);

   back_state_type        state_ff, state_in;
   logic [WORD_BITS-1:0]  quot_ff, quot_in;
   logic [5:0]            rem_ff, rem_in;
   logic [5:0]            radix_ff, radix_in;
   logic [IDX_BITS-1:0]   bit_ff, bit_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic                  minus_ff, minus_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [6:0]            char_ff, char_in;
   logic                  last_ff, last_in;
   logic                  bad_ff, bad_in;

   logic [6:0]            shifted;
   logic                  take;
   logic [5:0]            rem_next;
   logic [WORD_BITS-1:0]  quot_next;
   logic                  digit_done;
   logic                  out_free;

   logic                  ram_wr_en;
   logic                  ram_rd_en;
   logic [IDX_BITS-1:0]   ram_rd_addr;
   logic [5:0]            ram_rd_data;

   // one restoring division step per cycle
   assign shifted    = {rem_ff, quot_ff[WORD_BITS-1]};
   assign take       = shifted >= {1'b0, radix_ff};
   assign rem_next   = take ? 6'(shifted - {1'b0, radix_ff}) : shifted[5:0];
   assign quot_next  = {quot_ff[WORD_BITS-2:0], take};
   assign digit_done = (bit_ff == IDX_BITS'(WORD_BITS - 1));
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE: begin
            if (!queue_empty) begin
               state_in = job_info.bad ? B_ERR : B_DIV;
            end
         end
         B_ERR: begin
            if (out_free) begin
               state_in = B_IDLE;
            end
         end
         B_DIV: begin
            if (digit_done && (quot_next == '0)) begin
               state_in = B_SIGN;
            end
         end
         B_SIGN: begin
            if (!minus_ff || out_free) begin
               state_in = B_READ;
            end
         end
         B_READ: begin
            state_in = B_EMIT;
         end
         B_EMIT: begin
            if (out_free) begin
               state_in = (count_ff == CNT_BITS'(1)) ? B_IDLE : B_READ;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   // datapath and output register control
   always_comb begin
      quot_in      = quot_ff;
      rem_in       = rem_ff;
      radix_in     = radix_ff;
      bit_in       = bit_ff;
      count_in     = count_ff;
      minus_in     = minus_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      char_in      = char_ff;
      last_in      = last_ff;
      bad_in       = bad_ff;
      queue_pop    = 1'b0;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = IDX_BITS'(count_ff - CNT_BITS'(1));
      case (state_ff)
         B_IDLE: begin
            if (!queue_empty) begin
               queue_pop = 1'b1;
               quot_in   = job_mag;
               rem_in    = '0;
               radix_in  = job_info.radix;
               bit_in    = '0;
               count_in  = '0;
               minus_in  = job_info.minus;
            end
         end
         B_ERR: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               char_in      = '0;
               last_in      = 1'b1;
               bad_in       = 1'b1;
            end
         end
         B_DIV: begin
            quot_in = quot_next;
            if (digit_done) begin
               ram_wr_en = 1'b1;
               rem_in    = '0;
               bit_in    = '0;
               count_in  = count_ff + CNT_BITS'(1);
            end else begin
               rem_in = rem_next;
               bit_in = bit_ff + IDX_BITS'(1);
            end
         end
         B_SIGN: begin
            if (minus_ff && out_free) begin
               rsp_valid_in = 1'b1;
               char_in      = MINUS_CODE;
               last_in      = 1'b0;
               bad_in       = 1'b0;
               minus_in     = 1'b0;
            end
         end
         B_READ: begin
            ram_rd_en = 1'b1;
         end
         B_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               char_in      = digit_glyph(ram_rd_data);
               last_in      = (count_ff == CNT_BITS'(1));
               bad_in       = 1'b0;
               count_in     = count_ff - CNT_BITS'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         count_ff     <= '0;
         minus_ff     <= 1'b0;
         bit_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         minus_ff     <= minus_in;
         bit_ff       <= bit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      quot_ff  <= quot_in;
      rem_ff   <= rem_in;
      radix_ff <= radix_in;
      char_ff  <= char_in;
      last_ff  <= last_in;
      bad_ff   <= bad_in;
   end

   // digit store, least significant digit at address zero
   itrt_ram #(
      .WIDTH (6),
      .DEPTH (WORD_BITS)
   ) u_digits (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (count_ff[IDX_BITS-1:0]),
      .wr_data (rem_next),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_code = char_ff;
   assign rsp_last      = last_ff;
   assign rsp_bad_radix = bad_ff;

endmodule

### dv/tb_top.sv
module tb_top;
   import itrt_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int WORD_BITS = 32;
   localparam int PROBE_ROWS = 25;
   localparam int RANDOM_ITEMS = 435;
   localparam int DRAIN_EVERY = 115;

   // one character of converted text as it leaves the block
   typedef struct packed {
      logic [6:0] char_code;
      logic       last;
      logic       bad_radix;
   } text_char_type;

   // how the expected text of a directed row is found
   typedef enum {
      ROW_PREDICT,
      ROW_TEXT,
      ROW_BAD
   } row_kind_type;

   typedef struct {
      row_kind_type                kind;
      logic signed [WORD_BITS-1:0] value;
      logic [5:0]                  radix;
      string                       text;
   } probe_row_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic signed [WORD_BITS-1:0] req_value = '0;
   logic [5:0]                  req_radix = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [6:0]                  rsp_char_code;
   logic                        rsp_last;
   logic                        rsp_bad_radix;

   text_char_type expected_chars [$];
   bit            failed = 1'b0;
   bit            send_calm = 1'b0;
   bit            rsp_calm = 1'b0;
   int unsigned   stall_left = 0;

   // extremes, every sign rule, zero, and bad bases
   probe_row_type probe_rows [PROBE_ROWS] = '{
      '{ROW_TEXT,    0,            6'd10, "0"},
      '{ROW_TEXT,    0,            6'd2,  "0"},
      '{ROW_TEXT,    0,            6'd36, "0"},
      '{ROW_TEXT,    32'h7FFF_FFFF, 6'd10, "2147483647"},
      '{ROW_TEXT,    32'h8000_0000, 6'd10, "-2147483648"},
      '{ROW_TEXT,    32'h8000_0000, 6'd2,  "10000000000000000000000000000000"},
      '{ROW_TEXT,    32'h8000_0000, 6'd16, "80000000"},
      '{ROW_TEXT,    -1,           6'd10, "-1"},
      '{ROW_TEXT,    -1,           6'd16, "1"},
      '{ROW_TEXT,    -1,           6'd2,  "1"},
      '{ROW_TEXT,    32'h7FFF_FFFF, 6'd2,  "1111111111111111111111111111111"},
      '{ROW_PREDICT, 32'h7FFF_FFFF, 6'd36, ""},
      '{ROW_TEXT,    35,           6'd36, "Z"},
      '{ROW_TEXT,    255,          6'd16, "FF"},
      '{ROW_TEXT,    -255,         6'd16, "FF"},
      '{ROW_TEXT,    -42,          6'd10, "-42"},
      '{ROW_PREDICT, 12345,        6'd7,  ""},
      '{ROW_BAD,     100,          6'd0,  ""},
      '{ROW_BAD,     -7,           6'd1,  ""},
      '{ROW_BAD,     12,           6'd37, ""},
      '{ROW_BAD,     32'h8000_0000, 6'd63, ""},
      '{ROW_PREDICT, 32'h8000_0000, 6'd36, ""},
      '{ROW_TEXT,    10,           6'd10, "10"},
      '{ROW_TEXT,    36,           6'd36, "10"},
      '{ROW_PREDICT, 1234567,      6'd3,  ""}
   };

   integer_to_radix_text_top #(
      .WORD_BITS(WORD_BITS)
   ) dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_value    (req_value),
      .req_radix    (req_radix),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_char_code(rsp_char_code),
      .rsp_last     (rsp_last),
      .rsp_bad_radix(rsp_bad_radix)
   );

   always #5 clock = ~clock;

   // queue the characters one conversion should produce
   function automatic void spell_value(input logic signed [WORD_BITS-1:0] value,
                                       input logic [5:0] radix);
      logic [WORD_BITS-1:0] magnitude;
      logic [5:0]           digits [WORD_BITS];
      logic [6:0]           code;
      int                   count;
      if (radix < MIN_RADIX || radix > MAX_RADIX) begin
         expected_chars.push_back('{7'd0, 1'b1, 1'b1});
         return;
      end
      // magnitude stays unsigned so the most negative value is exact
      magnitude = value[WORD_BITS-1] ? (~value + 1'b1) : value;
      if (value[WORD_BITS-1] && radix == DECIMAL_BASE) begin
         expected_chars.push_back('{MINUS_CODE, 1'b0, 1'b0});
      end
      count = 0;
      do begin
         digits[count] = 6'(magnitude % radix);
         count++;
         magnitude = magnitude / radix;
      end while (magnitude != 0);
      // most significant digit first
      for (int i = count - 1; i >= 0; i--) begin
         if (digits[i] < 6'd10) begin
            code = ZERO_CODE + 7'(digits[i]);
         end else begin
            code = LETTER_CODE + 7'(digits[i]) - 7'd10;
         end
         expected_chars.push_back('{code, i == 0, 1'b0});
      end
   endfunction

   // drive one item and hold it until the transfer
   task automatic transfer_item(input logic signed [WORD_BITS-1:0] value,
                                input logic [5:0] radix);
      req_value <= value;
      req_radix <= radix;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // random gap after a transfer, with calm stretches of back-to-back items
   task automatic rest_sender();
      int unsigned gap;
      if ($urandom_range(0, 29) == 0) send_calm = !send_calm;
      gap = send_calm ? 0 : $urandom_range(0, 19);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // hold off the sender until every pending character is out
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_chars.size() != 0) @(posedge clock);
   endtask

   // result side: check each transfer, then stall for a random while
   always @(posedge clock) begin : rsp_side
      text_char_type got;
      text_char_type want;
      int unsigned   hold;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_char_code, rsp_last, rsp_bad_radix};
         if (expected_chars.size() == 0) begin
            $display("%0t: unexpected char %h last %b bad_radix %b",
                     $time, got.char_code, got.last, got.bad_radix);
            failed = 1'b1;
         end else begin
            want = expected_chars.pop_front();
            if (got != want) begin
               $display({"%0t: expected char %h last %b bad_radix %b, ",
                         "got char %h last %b bad_radix %b"},
                        $time, want.char_code, want.last, want.bad_radix,
                        got.char_code, got.last, got.bad_radix);
               failed = 1'b1;
            end
         end
         if ($urandom_range(0, 63) == 0) rsp_calm = !rsp_calm;
         hold = rsp_calm ? 0 : $urandom_range(0, 19);
         rsp_stall <= (hold != 0);
         stall_left <= hold;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= (stall_left > 1);
      end
   end

   // stimulus: directed rows, then random items
   initial begin
      logic signed [WORD_BITS-1:0] value;
      logic [5:0]                  radix;
      int                          pick;
      int                          len;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (probe_rows[r]) begin
         transfer_item(probe_rows[r].value, probe_rows[r].radix);
         case (probe_rows[r].kind)
            ROW_TEXT: begin
               len = probe_rows[r].text.len();
               for (int c = 0; c < len; c++) begin
                  expected_chars.push_back('{7'(probe_rows[r].text[c]), c == len - 1, 1'b0});
               end
            end
            ROW_BAD: begin
               expected_chars.push_back('{7'd0, 1'b1, 1'b1});
            end
            default: begin
               spell_value(probe_rows[r].value, probe_rows[r].radix);
            end
         endcase
         rest_sender();
      end
      drain_results();

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         // value: full range, small, shifted-down, or an extreme
         pick = $urandom_range(0, 4);
         case (pick)
            0: value = $urandom_range(0, 40);
            1: value = $urandom >> $urandom_range(0, 31);
            2: begin
               case ($urandom_range(0, 3))
                  0: value = 32'h8000_0000;
                  1: value = 32'h7FFF_FFFF;
                  2: value = -1;
                  default: value = 0;
               endcase
            end
            default: value = $urandom;
         endcase
         if (pick < 2 && $urandom_range(0, 1) == 1) value = -value;
         // radix: mostly valid, decimal often for the sign, some out of range
         pick = $urandom_range(0, 9);
         if (pick == 0) begin
            radix = $urandom_range(0, 1) ? 6'($urandom_range(37, 63)) : 6'($urandom_range(0, 1));
         end else if (pick < 3) begin
            radix = DECIMAL_BASE;
         end else begin
            radix = 6'($urandom_range(2, 36));
         end
         transfer_item(value, radix);
         spell_value(value, radix);
         if (i % DRAIN_EVERY == DRAIN_EVERY - 1) begin
            drain_results();
         end else begin
            rest_sender();
         end
      end

      drain_results();
      repeat (200) @(posedge clock);
      if (failed) begin
         $display("Simulation FAILED");
      end else begin
         $display("Simulation PASSED");
      end
      $finish;
   end

   // hang guard
   initial begin
      #40_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

### sim.f
design/itrt_pkg.sv
design/itrt_ram.sv
design/itrt_front.sv
design/itrt_queue.sv
design/itrt_back.sv
design/integer_to_radix_text_top.sv
dv/tb_top.sv
